[sv/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// Antenna rotor position controller package
// Shared widths, command codes, register indexes and the drive state record.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int ADC_BITS_DEF  = 10;
   localparam int AZ_BITS       = 10;
   localparam int QUO_BITS      = 9;
   localparam int OP_BITS       = 3;
   localparam int DIR_BITS      = 2;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_LSB   = 2;

   localparam logic [OP_BITS-1:0] OP_SAMPLE = 3'd0;
   localparam logic [OP_BITS-1:0] OP_TURN   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_PRESET = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PARK   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_STOP   = 3'd4;

   localparam logic [DIR_BITS-1:0] MV_NO  = 2'd0;
   localparam logic [DIR_BITS-1:0] MV_CW  = 2'd1;
   localparam logic [DIR_BITS-1:0] MV_CCW = 2'd2;

   localparam logic [1:0] REG_RAW_MIN = 2'd0;
   localparam logic [1:0] REG_RAW_MAX = 2'd1;
   localparam logic [1:0] REG_PARK    = 2'd2;
   localparam logic [1:0] REG_OFFSET  = 2'd3;

   localparam logic signed [AZ_BITS-1:0] AZ_FULL = 10'sd360;
   localparam logic signed [AZ_BITS-1:0] AZ_HALF = 10'sd180;
   localparam logic [QUO_BITS-1:0]       QUO_HALF = 9'd180;

   typedef struct packed {
      logic [DIR_BITS-1:0] motion;
      logic                auto_on;
      logic                cw;
      logic                ccw;
      logic                brake;
      logic                stopped;
   } drive_type;

endpackage

[sv/arpc_req_if.sv]
// ----------------------------------------------------------------------------
// Rotor command channel
// Carries one command or position sample per beat.
// ----------------------------------------------------------------------------
interface arpc_req_if
   import arpc_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic [OP_BITS-1:0]         op;
   logic [ADC_BITS-1:0]        adc_sample;
   logic [DIR_BITS-1:0]        direction;
   logic signed [AZ_BITS-1:0]  target_azimuth;

   modport source (output valid, op, adc_sample, direction, target_azimuth, input ready);
   modport sink   (input valid, op, adc_sample, direction, target_azimuth, output ready);
endinterface

[sv/arpc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Rotor status channel
// Carries the drive outputs and position after each command, one per beat.
// ----------------------------------------------------------------------------
interface arpc_rsp_if
   import arpc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       drive_cw;
   logic                       drive_ccw;
   logic                       brake_released;
   logic signed [AZ_BITS-1:0]  azimuth_now;
   logic [DIR_BITS-1:0]        motion;
   logic                       auto_active;
   logic                       stop_event;

   modport source (output valid, drive_cw, drive_ccw, brake_released, azimuth_now, motion,
                   auto_active, stop_event, input ready);
   modport sink   (input valid, drive_cw, drive_ccw, brake_released, azimuth_now, motion,
                   auto_active, stop_event, output ready);
endinterface

[sv/antenna_rotor_position_controller.sv]
// ----------------------------------------------------------------------------
// Antenna rotor position controller
// Scales position samples to degrees with a bit-serial divider and drives the
// clockwise, counter-clockwise and brake outputs of an azimuth rotor.
// ----------------------------------------------------------------------------
// A command goes from the accepted beat to ST_FINISH; a sample passes ST_SCALE,
// the one-bit-per-cycle restoring divider in ST_DIV and ST_FIX, or only ST_SCALE
// when the span is empty or the reading lies at or beyond the clockwise end.
// One beat is in flight at a time, until its status is loaded into the output.
// Synchronous reset stops the rotor, engages the brake and restores the
// register defaults; a pending status beat is discarded.
// ----------------------------------------------------------------------------
module antenna_rotor_position_controller
   import arpc_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   arpc_req_if.sink                 req,
   arpc_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int QW       = ADC_BITS + QUO_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS);
   localparam logic [QW-1:0]       SCALE_MUL = QW'(360);
   localparam logic [CNT_BITS-1:0] CNT_LAST  = CNT_BITS'(QUO_BITS - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_SCALE, ST_DIV, ST_FIX, ST_FINISH} state_type;

   state_type                  state_ff, state_in;
   logic [ADC_BITS-1:0]        raw_min_ff, raw_max_ff;
   logic signed [AZ_BITS-1:0]  park_ff;
   logic                       offset_ff;
   logic signed [AZ_BITS-1:0]  azimuth_ff, azimuth_in;
   logic signed [AZ_BITS-1:0]  preset_ff, preset_in;
   drive_type                  drv_ff, drv_in;
   logic [OP_BITS-1:0]         op_ff;
   logic [ADC_BITS-1:0]        raw_ff;
   logic [DIR_BITS-1:0]        dir_ff;
   logic signed [AZ_BITS-1:0]  target_ff;
   logic [ADC_BITS-1:0]        span_ff, span_in;
   logic [ADC_BITS-1:0]        rem_ff, rem_in;
   logic [QUO_BITS-1:0]        qlo_ff, qlo_in;
   logic [QUO_BITS-1:0]        quo_ff, quo_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   drive_type                  out_ff, out_in;
   logic signed [AZ_BITS-1:0]  out_az_ff, out_az_in;

   logic                       req_take, csr_write, out_load;
   logic [1:0]                 csr_idx;
   logic [ADC_BITS-1:0]        span_w, dist_w;
   logic [QW-1:0]              prod_w;
   logic [ADC_BITS:0]          trial_w;
   logic                       fit_w;
   logic signed [AZ_BITS-1:0]  quo_s, round_s;
   drive_type                  cur_w, fin_w;

   function automatic drive_type stop_act(drive_type s, logic clr, logic offs);
      drive_type r;
      r        = s;
      r.motion = MV_NO;
      if (clr) begin
         r.auto_on = 1'b0;
      end
      r.cw  = 1'b0;
      r.ccw = 1'b0;
      if (offs) begin
         r.brake = 1'b0;
      end
      return r;
   endfunction

   function automatic drive_type turn_act(drive_type s, logic [DIR_BITS-1:0] dir, logic offs);
      drive_type r;
      logic      pin;
      r   = s;
      pin = (dir == MV_CW) ? s.cw : s.ccw;
      if (!pin) begin
         if (r.brake) begin
            r = stop_act(r, 1'b0, offs);
         end
         r.brake = 1'b1;
         if (dir == MV_CW) begin
            r.cw = 1'b1;
         end else begin
            r.ccw = 1'b1;
         end
         r.motion = dir;
      end
      return r;
   endfunction

   function automatic drive_type seek_act(drive_type s, logic signed [AZ_BITS-1:0] az,
                                          logic signed [AZ_BITS-1:0] goal, logic offs);
      drive_type r;
      r = s;
      if (az < goal) begin
         r.auto_on = 1'b1;
         r         = turn_act(r, MV_CW, offs);
      end else if (az > goal) begin
         r.auto_on = 1'b1;
         r         = turn_act(r, MV_CCW, offs);
      end else begin
         r         = stop_act(r, 1'b1, offs);
         r.stopped = 1'b1;
      end
      return r;
   endfunction

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_IDX_LSB +: 2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (csr_idx)
         REG_RAW_MIN: prdata = CSR_DATA_BITS'(raw_min_ff);
         REG_RAW_MAX: prdata = CSR_DATA_BITS'(raw_max_ff);
         REG_PARK:    prdata = CSR_DATA_BITS'(unsigned'(park_ff));
         REG_OFFSET:  prdata = CSR_DATA_BITS'(offset_ff);
         default:     prdata = '0;
      endcase
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign req_take           = req.valid && req.ready;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.drive_cw       = out_ff.cw;
   assign rsp.drive_ccw      = out_ff.ccw;
   assign rsp.brake_released = out_ff.brake;
   assign rsp.azimuth_now    = out_az_ff;
   assign rsp.motion         = out_ff.motion;
   assign rsp.auto_active    = out_ff.auto_on;
   assign rsp.stop_event     = out_ff.stopped;

   assign span_w  = raw_max_ff - raw_min_ff;
   assign dist_w  = (raw_ff > raw_min_ff) ? (raw_ff - raw_min_ff) : '0;
   assign prod_w  = {{QUO_BITS{1'b0}}, dist_w} * SCALE_MUL;
   assign trial_w = {rem_ff, qlo_ff[QUO_BITS-1]};
   assign fit_w   = (trial_w >= {1'b0, span_ff});
   assign quo_s   = signed'({1'b0, quo_ff});
   assign round_s = ((quo_ff < QUO_HALF) && (rem_ff != '0)) ? AZ_BITS'(1) : '0;

   assign cur_w = '{motion: drv_ff.motion, auto_on: drv_ff.auto_on, cw: drv_ff.cw,
                    ccw: drv_ff.ccw, brake: drv_ff.brake, stopped: 1'b0};

   always_comb begin
      fin_w     = cur_w;
      preset_in = preset_ff;
      case (op_ff)
         OP_SAMPLE: begin
            if (drv_ff.auto_on) begin
               if (((drv_ff.motion == MV_CCW) && (preset_ff >= azimuth_ff)) ||
                   ((drv_ff.motion == MV_CW) && (preset_ff <= azimuth_ff)) ||
                   ((drv_ff.motion != MV_CCW) && (drv_ff.motion != MV_CW))) begin
                  fin_w         = stop_act(cur_w, 1'b1, offset_ff);
                  fin_w.stopped = 1'b1;
               end
            end else if (((drv_ff.motion == MV_CCW) && (raw_ff <= raw_min_ff)) ||
                         ((drv_ff.motion == MV_CW) && (raw_ff >= raw_max_ff))) begin
               fin_w         = stop_act(cur_w, 1'b1, offset_ff);
               fin_w.stopped = 1'b1;
            end
         end
         OP_TURN: begin
            if ((dir_ff == MV_CW) || (dir_ff == MV_CCW)) begin
               fin_w = turn_act(cur_w, dir_ff, offset_ff);
            end else begin
               fin_w         = stop_act(cur_w, 1'b1, offset_ff);
               fin_w.stopped = 1'b1;
            end
         end
         OP_PRESET: begin
            preset_in = target_ff;
            fin_w     = seek_act(cur_w, azimuth_ff, target_ff, offset_ff);
         end
         OP_PARK: begin
            preset_in = park_ff;
            fin_w     = seek_act(cur_w, azimuth_ff, park_ff, offset_ff);
         end
         OP_STOP: begin
            fin_w         = stop_act(cur_w, 1'b1, offset_ff);
            fin_w.stopped = 1'b1;
         end
         default: begin
            fin_w = cur_w;
         end
      endcase
   end

   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in     = state_ff;
      azimuth_in   = azimuth_ff;
      drv_in       = drv_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      qlo_in       = qlo_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_az_in    = out_az_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req.op == OP_SAMPLE) ? ST_SCALE : ST_FINISH;
            end
         end
         ST_SCALE: begin
            span_in = span_w;
            rem_in  = prod_w[QW-1 -: ADC_BITS];
            qlo_in  = prod_w[QUO_BITS-1:0];
            quo_in  = '0;
            cnt_in  = '0;
            if (raw_max_ff <= raw_min_ff) begin
               azimuth_in = '0;
               state_in   = ST_FINISH;
            end else if (dist_w >= span_w) begin
               azimuth_in = offset_ff ? AZ_HALF : AZ_FULL;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = fit_w ? ADC_BITS'(trial_w - {1'b0, span_ff}) : trial_w[ADC_BITS-1:0];
            qlo_in = {qlo_ff[QUO_BITS-2:0], 1'b0};
            quo_in = {quo_ff[QUO_BITS-2:0], fit_w};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            azimuth_in = offset_ff ? (quo_s - AZ_HALF + round_s) : quo_s;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_load) begin
               drv_in       = fin_w;
               out_in       = fin_w;
               out_az_in    = azimuth_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         raw_min_ff   <= '0;
         raw_max_ff   <= '1;
         park_ff      <= '0;
         offset_ff    <= 1'b0;
         azimuth_ff   <= '0;
         preset_ff    <= '0;
         drv_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         azimuth_ff   <= azimuth_in;
         drv_ff       <= drv_in;
         if (out_load) begin
            preset_ff <= preset_in;
         end
         if (csr_write) begin
            case (csr_idx)
               REG_RAW_MIN: raw_min_ff <= pwdata[ADC_BITS-1:0];
               REG_RAW_MAX: raw_max_ff <= pwdata[ADC_BITS-1:0];
               REG_PARK:    park_ff    <= signed'(pwdata[AZ_BITS-1:0]);
               REG_OFFSET:  offset_ff  <= pwdata[0];
               default:     offset_ff  <= offset_ff;
            endcase
         end
      end
      if (req_take) begin
         op_ff     <= req.op;
         raw_ff    <= req.adc_sample;
         dir_ff    <= req.direction;
         target_ff <= req.target_azimuth;
      end
      span_ff   <= span_in;
      rem_ff    <= rem_in;
      qlo_ff    <= qlo_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      out_ff    <= out_in;
      out_az_ff <= out_az_in;
   end

   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(drv_ff.cw && drv_ff.ccw) && (drv_ff.brake || (!drv_ff.cw && !drv_ff.ccw)))
      else $error("both drive pins high or a pin high with the brake engaged");

   a_motion_pins: assert property (@(posedge clock) disable iff (reset)
      ((drv_ff.motion == MV_CW) == drv_ff.cw) && ((drv_ff.motion == MV_CCW) == drv_ff.ccw))
      else $error("motion code disagrees with drive pins");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("second beat accepted while one is in flight");

endmodule

[bench/tb_antenna_rotor_position_controller.sv]
// ----------------------------------------------------------------------------
// Antenna rotor position controller testbench
// Drives commands and position samples into the controller under random
// idling on both channels, predicts each status beat from its own model of the
// scaling and stop rules or takes it from a table of fixed beats, and checks
// the beats field by field. Register settings change between phases while the
// block is idle, and the registers are read back after each setting is written.
// ----------------------------------------------------------------------------
module tb_antenna_rotor_position_controller;
   import arpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES    = 250000;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_AT         = 600;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 16;

   localparam logic [OP_BITS-1:0]  OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_BITS-1:0]  OP_SPARE_LAST  = 3'd7;
   localparam logic [DIR_BITS-1:0] DIR_SPARE      = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]        op;
      logic [ADC_BITS_DEF-1:0]   adc;
      logic [DIR_BITS-1:0]       dir;
      logic signed [AZ_BITS-1:0] target;
   } command_type;

   typedef struct packed {
      logic                      cw;
      logic                      ccw;
      logic                      brake;
      logic signed [AZ_BITS-1:0] az;
      logic [DIR_BITS-1:0]       motion;
      logic                      auto_on;
      logic                      stop;
   } status_type;

   typedef struct {
      command_type cmd;
      bit          typed;
      status_type  want;
   } plan_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   arpc_req_if req_bus ();
   arpc_rsp_if rsp_bus ();

   antenna_rotor_position_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted rotor state and register copies.
   logic [9:0]        cfg_lo;
   logic [9:0]        cfg_hi;
   logic signed [9:0] cfg_park;
   bit                cfg_offset;
   int                pos_deg;
   int                goal_deg;
   logic [1:0]        mv;
   bit                auto_on;
   bit                pin_cw;
   bit                pin_ccw;
   bit                brake_off;

   status_type   status_due [$];
   plan_row_type plan [$];

   int  errors;
   int  cycles;
   int  items_sent;
   int  beats_seen;
   int  stops_seen;
   int  settings_used;
   int  sink_wait;
   int  lead_gap;
   int  rotor_raw;
   bit  source_calm;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   function automatic int to_degrees(input int raw);
      int lo, hi, span, d, q, half;
      lo = int'(cfg_lo);
      hi = int'(cfg_hi);
      if (hi <= lo) return 0;
      span = hi - lo;
      d = (raw > lo) ? raw - lo : 0;
      if (d >= span) return cfg_offset ? 180 : 360;
      q = d * 360;
      if (!cfg_offset) return q / span;
      half = span * 180;
      if (q >= half) return (q - half) / span;
      return -((half - q) / span);
   endfunction

   function automatic void halt(input bit drop_auto);
      mv = MV_NO;
      if (drop_auto) auto_on = 1'b0;
      pin_cw = 1'b0;
      pin_ccw = 1'b0;
      if (cfg_offset) brake_off = 1'b0;
   endfunction

   function automatic void engage(input logic [1:0] dir);
      if ((dir == MV_CW) ? pin_cw : pin_ccw) return;
      if (brake_off) halt(1'b0);
      brake_off = 1'b1;
      if (dir == MV_CW) pin_cw = 1'b1;
      else pin_ccw = 1'b1;
      mv = dir;
   endfunction

   function automatic bit seek_goal();
      if (pos_deg < goal_deg) begin
         auto_on = 1'b1;
         engage(MV_CW);
         return 1'b0;
      end
      if (pos_deg > goal_deg) begin
         auto_on = 1'b1;
         engage(MV_CCW);
         return 1'b0;
      end
      halt(1'b1);
      return 1'b1;
   endfunction

   function automatic void step_rotor(input command_type c, output status_type s);
      bit stopped;
      stopped = 1'b0;
      case (c.op)
         OP_SAMPLE: begin
            pos_deg = to_degrees(int'(c.adc));
            if (auto_on) begin
               if (mv == MV_CCW) stopped = (goal_deg >= pos_deg);
               else if (mv == MV_CW) stopped = (goal_deg <= pos_deg);
               else stopped = 1'b1;
            end else begin
               stopped = (mv == MV_CCW && c.adc <= cfg_lo) || (mv == MV_CW && c.adc >= cfg_hi);
            end
            if (stopped) halt(1'b1);
         end
         OP_TURN: begin
            if (c.dir == MV_CW || c.dir == MV_CCW) begin
               engage(c.dir);
            end else begin
               halt(1'b1);
               stopped = 1'b1;
            end
         end
         OP_PRESET: begin
            goal_deg = int'(c.target);
            stopped = seek_goal();
         end
         OP_PARK: begin
            goal_deg = int'(cfg_park);
            stopped = seek_goal();
         end
         OP_STOP: begin
            halt(1'b1);
            stopped = 1'b1;
         end
         default: begin
         end
      endcase
      s.cw = pin_cw;
      s.ccw = pin_ccw;
      s.brake = brake_off;
      s.az = 10'(pos_deg);
      s.motion = mv;
      s.auto_on = auto_on;
      s.stop = stopped;
   endfunction

   task automatic check_status(input status_type want, input status_type got);
      check_field("drive_cw", int'(want.cw), int'(got.cw));
      check_field("drive_ccw", int'(want.ccw), int'(got.ccw));
      check_field("brake_released", int'(want.brake), int'(got.brake));
      check_field("azimuth_now", int'($signed(want.az)), int'($signed(got.az)));
      check_field("motion", int'(want.motion), int'(got.motion));
      check_field("auto_active", int'(want.auto_on), int'(got.auto_on));
      check_field("stop_event", int'(want.stop), int'(got.stop));
   endtask

   // Status sink: random hold-off per beat, calm stretches, and one long hold.
   always @(posedge clock) begin
      status_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.cw = rsp_bus.drive_cw;
            got.ccw = rsp_bus.drive_ccw;
            got.brake = rsp_bus.brake_released;
            got.az = rsp_bus.azimuth_now;
            got.motion = rsp_bus.motion;
            got.auto_on = rsp_bus.auto_active;
            got.stop = rsp_bus.stop_event;
            beats_seen++;
            if (got.stop) stops_seen++;
            if (status_due.size() == 0) begin
               errors++;
               $display("%0t: status beat with nothing expected, expected none, actual %h",
                        $time, got);
            end else begin
               check_status(status_due.pop_front(), got);
            end
            if (beats_seen == HOLD_AT) sink_wait = HOLD_CYCLES;
            else if ((beats_seen / 250) % 4 == 3) sink_wait = 0;
            else sink_wait = $urandom_range(0, 3);
         end else if (sink_wait != 0) begin
            sink_wait--;
         end
         rsp_bus.ready <= (sink_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic reg_write(input logic [1:0] idx, input logic [9:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_IDX_LSB;
      pwdata <= {22'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic reg_check(input logic [1:0] idx, input logic [9:0] value, input int width);
      logic [CSR_DATA_BITS-1:0] rd;
      logic [CSR_DATA_BITS-1:0] mask;
      mask = (32'd1 << width) - 32'd1;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_IDX_LSB;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      rd = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      check_field($sformatf("register %0d readback", idx),
                  int'({22'd0, value} & mask), int'(rd & mask));
   endtask

   task automatic apply_setup(input logic [9:0] lo, input logic [9:0] hi,
                              input logic signed [9:0] park, input bit ofs);
      reg_write(REG_RAW_MIN, lo);
      reg_write(REG_RAW_MAX, hi);
      reg_write(REG_PARK, park);
      reg_write(REG_OFFSET, {9'd0, ofs});
      cfg_lo = lo;
      cfg_hi = hi;
      cfg_park = park;
      cfg_offset = ofs;
      settings_used++;
      reg_check(REG_RAW_MIN, lo, 10);
      reg_check(REG_RAW_MAX, hi, 10);
      reg_check(REG_PARK, park, 10);
      reg_check(REG_OFFSET, {9'd0, ofs}, 1);
   endtask

   task automatic offer(input command_type c, input bit typed, input status_type want);
      status_type s;
      repeat (lead_gap) @(posedge clock);
      req_bus.valid <= 1'b1;
      req_bus.op <= c.op;
      req_bus.adc_sample <= c.adc;
      req_bus.direction <= c.dir;
      req_bus.target_azimuth <= c.target;
      do @(posedge clock); while (!req_bus.ready);
      step_rotor(c, s);
      status_due.push_back(typed ? want : s);
      items_sent++;
      lead_gap = source_calm ? 0 : $urandom_range(0, 3);
      if (lead_gap != 0) req_bus.valid <= 1'b0;
   endtask

   task automatic quiet_source();
      if (lead_gap == 0) req_bus.valid <= 1'b0;
      lead_gap = 1;
   endtask

   task automatic drain();
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic random_items(input int count);
      command_type c;
      int pick;
      int pick_dir;
      repeat (count) begin
         c.op = OP_SAMPLE;
         c.adc = 10'($urandom);
         c.dir = 2'($urandom);
         c.target = 10'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) rotor_raw = $urandom_range(0, 1023);
            else if (mv == MV_CW) rotor_raw = rotor_raw + $urandom_range(0, 40);
            else if (mv == MV_CCW) rotor_raw = rotor_raw - $urandom_range(0, 40);
            if (rotor_raw > 1023) rotor_raw = 1023;
            if (rotor_raw < 0) rotor_raw = 0;
            c.adc = 10'(rotor_raw);
         end else if (pick < 70) begin
            c.op = OP_TURN;
            pick_dir = $urandom_range(0, 9);
            if (pick_dir < 4) c.dir = MV_CW;
            else if (pick_dir < 8) c.dir = MV_CCW;
            else if (pick_dir == 8) c.dir = MV_NO;
            else c.dir = DIR_SPARE;
         end else if (pick < 85) begin
            c.op = OP_PRESET;
            if ($urandom_range(0, 7) != 0) c.target = 10'($urandom_range(0, 540) - 180);
         end else if (pick < 91) begin
            c.op = OP_PARK;
         end else if (pick < 95) begin
            c.op = OP_STOP;
         end else begin
            c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end
         offer(c, 1'b0, '0);
      end
   endtask

   initial begin
      int ph;
      logic [9:0] lo;
      logic [9:0] hi;
      logic [9:0] tmp;
      logic signed [9:0] park;
      bit ofs;

      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_SAMPLE;
      req_bus.adc_sample <= '0;
      req_bus.direction <= MV_NO;
      req_bus.target_azimuth <= '0;

      cfg_lo = 10'd0;
      cfg_hi = 10'd1023;
      cfg_park = 10'sd0;
      cfg_offset = 1'b0;
      pos_deg = 0;
      goal_deg = 0;
      mv = MV_NO;
      auto_on = 1'b0;
      pin_cw = 1'b0;
      pin_ccw = 1'b0;
      brake_off = 1'b0;
      lead_gap = 0;
      rotor_raw = 512;
      source_calm = 1'b0;

      plan.push_back('{'{OP_STOP, 10'd0, MV_NO, 10'sd0}, 1'b1,
                       '{1'b0, 1'b0, 1'b0, 10'sd0, MV_NO, 1'b0, 1'b1}});
      plan.push_back('{'{OP_SPARE_LAST, 10'h3FF, DIR_SPARE, -10'sd1}, 1'b1,
                       '{1'b0, 1'b0, 1'b0, 10'sd0, MV_NO, 1'b0, 1'b0}});
      plan.push_back('{'{OP_SAMPLE, 10'd0, MV_NO, 10'sd0}, 1'b1,
                       '{1'b0, 1'b0, 1'b0, 10'sd0, MV_NO, 1'b0, 1'b0}});
      plan.push_back('{'{OP_SAMPLE, 10'd1023, DIR_SPARE, -10'sd1}, 1'b1,
                       '{1'b0, 1'b0, 1'b0, 10'sd360, MV_NO, 1'b0, 1'b0}});
      plan.push_back('{'{OP_SAMPLE, 10'd512, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_SAMPLE, 10'd1023, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CCW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CCW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_SAMPLE, 10'd0, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, MV_CCW, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_TURN, 10'd0, DIR_SPARE, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_PRESET, 10'd0, MV_NO, 10'sd90}, 1'b0, '0});
      plan.push_back('{'{OP_SAMPLE, 10'd200, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_SAMPLE, 10'd300, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_PRESET, 10'd0, MV_NO, -10'sd180}, 1'b0, '0});
      plan.push_back('{'{OP_SAMPLE, 10'd0, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_PRESET, 10'd0, MV_NO, 10'sd511}, 1'b0, '0});
      plan.push_back('{'{OP_PRESET, 10'd0, MV_NO, -10'sd512}, 1'b0, '0});
      plan.push_back('{'{OP_STOP, 10'h3FF, DIR_SPARE, -10'sd1}, 1'b0, '0});
      plan.push_back('{'{OP_PARK, 10'd0, MV_NO, 10'sd0}, 1'b0, '0});
      plan.push_back('{'{OP_SPARE_FIRST, 10'h3FF, DIR_SPARE, -10'sd1}, 1'b0, '0});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      reg_check(REG_RAW_MIN, 10'd0, 10);
      reg_check(REG_RAW_MAX, 10'd1023, 10);
      reg_check(REG_PARK, 10'd0, 10);
      reg_check(REG_OFFSET, 10'd0, 1);
      settings_used = 1;

      foreach (plan[i]) offer(plan[i].cmd, plan[i].typed, plan[i].want);

      for (ph = 0; ph < PHASES; ph++) begin
         quiet_source();
         drain();
         case (ph)
            0: apply_setup(10'd0, 10'd1023, 10'sd360, 1'b1);
            1: apply_setup(10'd1023, 10'd0, -10'sd180, 1'b0);
            2: apply_setup(10'd500, 10'd500, 10'sd511, 1'b1);
            3: apply_setup(10'd100, 10'd900, -10'sd512, 1'b0);
            4: apply_setup(10'd0, 10'd1, 10'sd0, 1'b1);
            default: begin
               lo = 10'($urandom);
               hi = 10'($urandom);
               if (hi < lo && $urandom_range(0, 4) != 0) begin
                  tmp = lo;
                  lo = hi;
                  hi = tmp;
               end
               park = 10'($urandom_range(0, 540) - 180);
               ofs = 1'($urandom_range(0, 1));
               apply_setup(lo, hi, park, ofs);
            end
         endcase
         source_calm = (ph % 3 == 2);
         random_items(ITEMS_PER_PHASE);
      end

      quiet_source();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands under %0d register settings; %0d status beats checked,",
               items_sent, settings_used, beats_seen);
      $display("%0d of them stop events, with one receiver hold of %0d cycles.",
               stops_seen, HOLD_CYCLES);
      if (errors == 0 && status_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
